@@ src/afu_pkg.sv @@
// Package for the activation function unit: widths, function selector codes,
// and the exponential lookup tables built at elaboration.
// No dependencies.
package afu_pkg;

   localparam int DataWidth  = 16;
   localparam int FracBits   = 10;
   localparam int FuncWidth  = 3;

   // internal exponential format: unsigned, ExpFrac fractional bits, holds 1.0
   localparam int ExpFrac    = 40;
   localparam int ExpWidth   = ExpFrac + 1;
   // numerator and denominator of the final quotient stay below 8.0
   localparam int NumWidth   = ExpFrac + 3;
   // one integer bit, FracBits fractional bits and a rounding bit
   localparam int QuotBits   = FracBits + 2;
   localparam int MulLatency = 2;

   // argument split for exp(-a) = exp(-hi) * exp(-mid) * exp(-lo)
   localparam int LoBits     = FracBits / 2;
   localparam int MidBits    = FracBits - LoBits;
   localparam int HiBits     = DataWidth - FracBits;

   // magnitude from which the exponential term is taken as zero
   localparam int SatInt     = 32;

   localparam int QWork       = 60;
   localparam int SeriesTerms = 24;
   localparam int Halvings    = 7;

   typedef enum logic [FuncWidth-1:0] {
      FuncSigmoid,
      FuncSigmoidDeriv,
      FuncRelu,
      FuncReluDeriv,
      FuncTanh,
      FuncTanhDeriv
   } func_type;

   typedef logic [(2**HiBits)-1:0][ExpWidth-1:0]  hi_table_type;
   typedef logic [(2**MidBits)-1:0][ExpWidth-1:0] mid_table_type;
   typedef logic [(2**LoBits)-1:0][ExpWidth-1:0]  lo_table_type;

   // (a * b) >> QWork, truncated
   function automatic logic [63:0] qwork_mul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] prod;
      prod = 128'(a) * 128'(b);
      return prod[QWork+63:QWork];
   endfunction

   // exp(-k / 2^shift) rounded to ExpFrac fractional bits
   function automatic logic [ExpWidth-1:0] exp_q(input int unsigned k,
                                                 input int unsigned shift);
      logic [63:0] v;
      logic [63:0] sum;
      logic [63:0] term;
      int unsigned n;
      v    = 64'(k) << (QWork - Halvings - shift);
      sum  = 64'd1 << QWork;
      term = sum;
      for (n = 1; n <= SeriesTerms; n++) begin
         term = qwork_mul(term, v) / 64'(n);
         if (n[0]) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      for (n = 0; n < Halvings; n++) begin
         sum = qwork_mul(sum, sum);
      end
      sum = sum + (64'd1 << (QWork - ExpFrac - 1));
      return ExpWidth'(sum >> (QWork - ExpFrac));
   endfunction

   function automatic hi_table_type build_hi_table();
      hi_table_type t;
      int unsigned k;
      for (k = 0; k < 2**HiBits; k++) begin
         t[k] = exp_q(k, 0);
      end
      return t;
   endfunction

   function automatic mid_table_type build_mid_table();
      mid_table_type t;
      int unsigned k;
      for (k = 0; k < 2**MidBits; k++) begin
         t[k] = exp_q(k, MidBits);
      end
      return t;
   endfunction

   function automatic lo_table_type build_lo_table();
      lo_table_type t;
      int unsigned k;
      for (k = 0; k < 2**LoBits; k++) begin
         t[k] = exp_q(k, FracBits);
      end
      return t;
   endfunction

endpackage

@@ src/afu_mul.sv @@
// Two-stage fixed-point multiplier: partial products, then sum and truncation.
// Result is (a * b) >> Frac. Defaults from afu_pkg.
module afu_mul #(
   parameter int Width = afu_pkg::ExpWidth,
   parameter int Frac  = afu_pkg::ExpFrac
) (
   input  logic             clock,
   input  logic [Width-1:0] a,
   input  logic [Width-1:0] b,
   output logic [Width-1:0] p
);

   localparam int LoW   = (Width + 1) / 2;
   localparam int HiW   = Width - LoW;
   localparam int ProdW = 2 * Width;

   logic [2*LoW-1:0]     pp_ll_ff;
   logic [LoW+HiW-1:0]   pp_lh_ff;
   logic [LoW+HiW-1:0]   pp_hl_ff;
   logic [2*HiW-1:0]     pp_hh_ff;
   logic [ProdW-1:0]     sum;
   logic [Width-1:0]     p_ff;

   always_ff @(posedge clock) begin
      pp_ll_ff <= a[LoW-1:0] * b[LoW-1:0];
      pp_lh_ff <= a[LoW-1:0] * b[Width-1:LoW];
      pp_hl_ff <= a[Width-1:LoW] * b[LoW-1:0];
      pp_hh_ff <= a[Width-1:LoW] * b[Width-1:LoW];
   end

   always_comb begin
      sum = ProdW'(pp_ll_ff)
          + (ProdW'(pp_lh_ff) << LoW)
          + (ProdW'(pp_hl_ff) << LoW)
          + (ProdW'(pp_hh_ff) << (2 * LoW));
   end

   always_ff @(posedge clock) begin
      p_ff <= sum[Frac +: Width];
   end

   assign p = p_ff;

endmodule

@@ src/afu_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, QuotBits stages.
// Needs num < 2 * den; quotient has one integer bit. Defaults from afu_pkg.
module afu_div #(
   parameter int Width    = afu_pkg::NumWidth,
   parameter int QuotBits = afu_pkg::QuotBits
) (
   input  logic                clock,
   input  logic [Width-1:0]    num,
   input  logic [Width-1:0]    den,
   output logic [QuotBits-1:0] quot
);

   logic [Width-1:0]    rem_ff   [QuotBits];
   logic [Width-1:0]    den_ff   [QuotBits];
   logic [QuotBits-1:0] quot_ff  [QuotBits];
   logic [Width-1:0]    rem_in   [QuotBits];
   logic [Width:0]      trial    [QuotBits];
   logic [Width-1:0]    den_src  [QuotBits];
   logic [QuotBits-1:0] quot_src [QuotBits];
   logic [Width:0]      diff     [QuotBits];
   logic                ge       [QuotBits];

   always_comb begin
      trial[0]    = {1'b0, num};
      den_src[0]  = den;
      quot_src[0] = '0;
      for (int k = 1; k < QuotBits; k++) begin
         trial[k]    = {rem_ff[k-1], 1'b0};
         den_src[k]  = den_ff[k-1];
         quot_src[k] = quot_ff[k-1];
      end
      for (int k = 0; k < QuotBits; k++) begin
         diff[k]   = trial[k] - {1'b0, den_src[k]};
         ge[k]     = trial[k] >= {1'b0, den_src[k]};
         rem_in[k] = ge[k] ? diff[k][Width-1:0] : trial[k][Width-1:0];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < QuotBits; k++) begin
         rem_ff[k]  <= rem_in[k];
         den_ff[k]  <= den_src[k];
         quot_ff[k] <= {quot_src[k][QuotBits-2:0], ge[k]};
      end
   end

   assign quot = quot_ff[QuotBits-1];

endmodule

@@ src/activation_function_unit.sv @@
// Activation function unit: sigmoid, tanh, ReLU and their derivatives on Q5.10.
// Depends on afu_pkg, afu_mul and afu_div.
//
// Usage
//   Input: a word (req_func, req_x) is taken at each rising edge with start
//   high and busy low. busy is always low, so a word may be offered in every
//   cycle: throughput is one word per clock.
//   Output: each result is on rsp_y for exactly one cycle with rsp_strobe
//   high, in input order, once its input word has passed the pipeline:
//   input register, table lookup of exp(-hi), exp(-mid), exp(-lo), three
//   two-stage multipliers (table products, then the square of the
//   exponential) with the large-argument zeroing register between them, the
//   numerator and denominator stage, a 12-stage restoring divider and the
//   output register.
//   ReLU, ReLU derivative and unused selectors ride the same pipeline.
//   Reset (synchronous, active high) drops every word in flight; no result
//   appears for words taken before it. The receiver cannot stall, so the
//   pipeline never holds and results leave as they are formed.
module activation_function_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic        [afu_pkg::FuncWidth-1:0] req_func,
   input  logic signed [afu_pkg::DataWidth-1:0] req_x,
   output logic                                rsp_strobe,
   output logic signed [afu_pkg::DataWidth-1:0] rsp_y
);

   import afu_pkg::*;

   localparam int StB       = 1;
   localparam int StMul1    = StB + MulLatency;
   localparam int StMul2    = StMul1 + MulLatency;
   localparam int StG       = StMul2 + 1;
   localparam int StMul3    = StG + MulLatency;
   localparam int StN       = StMul3 + 1;
   localparam int StDiv     = StN + QuotBits;
   localparam int SideDepth = StDiv + 1;

   localparam hi_table_type  HiTable  = build_hi_table();
   localparam mid_table_type MidTable = build_mid_table();
   localparam lo_table_type  LoTable  = build_lo_table();

   localparam logic [DataWidth:0]   SatLimit = (DataWidth + 1)'(SatInt) << FracBits;
   localparam logic [NumWidth-1:0]  QOne     = NumWidth'(1) << ExpFrac;
   localparam logic [DataWidth-1:0] YOne     = DataWidth'(1) << FracBits;

   typedef struct packed {
      logic [FuncWidth-1:0] func;
      logic [DataWidth-1:0] x;
   } side_type;

   side_type             side_ff   [SideDepth];
   logic [SideDepth-1:0] valid_ff;

   func_type             func_b;
   logic                 neg_b;
   logic                 tanh_b;
   logic                 sat_b;
   logic [DataWidth-1:0] ax_b;
   logic [DataWidth-1:0] arg_b;

   logic [ExpWidth-1:0]  t_hi_ff;
   logic [ExpWidth-1:0]  t_mid_ff;
   logic [ExpWidth-1:0]  t_lo_ff;
   logic                 sat_ff;
   logic [ExpWidth-1:0]  lo_dly_ff  [MulLatency];
   logic                 sat_dly_ff [2*MulLatency];
   logic [ExpWidth-1:0]  g_dly_ff   [MulLatency];

   logic [ExpWidth-1:0]  p_hm;
   logic [ExpWidth-1:0]  g_raw;
   logic [ExpWidth-1:0]  g_ff;
   logic [ExpWidth-1:0]  gg;

   logic [NumWidth-1:0]  g_n;
   logic [NumWidth-1:0]  gg_n;
   logic [NumWidth-1:0]  one_plus_g;
   logic [NumWidth-1:0]  one_plus_g_sq;
   logic                 neg_n;
   logic [NumWidth-1:0]  num_in;
   logic [NumWidth-1:0]  den_in;
   logic [NumWidth-1:0]  num_ff;
   logic [NumWidth-1:0]  den_ff;

   logic [QuotBits-1:0]  quot;
   logic [QuotBits:0]    quot_up;
   logic [DataWidth-1:0] mag;
   logic                 neg_o;
   logic [DataWidth-1:0] rsp_y_in;
   logic [DataWidth-1:0] rsp_y_ff;
   logic                 rsp_strobe_ff;

   assign busy = 1'b0;

   // valid bits and side words
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         valid_ff      <= {valid_ff[SideDepth-2:0], start & ~busy};
         rsp_strobe_ff <= valid_ff[StDiv];
      end
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= '{func: req_func, x: req_x};
      for (int k = 1; k < SideDepth; k++) begin
         side_ff[k] <= side_ff[k-1];
      end
   end

   // magnitude, argument split, table lookup
   always_comb begin
      func_b = func_type'(side_ff[0].func);
      neg_b  = side_ff[0].x[DataWidth-1];
      ax_b   = neg_b ? (~side_ff[0].x + DataWidth'(1)) : side_ff[0].x;
      sat_b  = {1'b0, ax_b} >= SatLimit;
      tanh_b = (func_b == FuncTanh) || (func_b == FuncTanhDeriv);
      arg_b  = tanh_b ? {ax_b[DataWidth-2:0], 1'b0} : ax_b;
   end

   always_ff @(posedge clock) begin
      t_hi_ff  <= HiTable[arg_b[DataWidth-1:FracBits]];
      t_mid_ff <= MidTable[arg_b[FracBits-1:LoBits]];
      t_lo_ff  <= LoTable[arg_b[LoBits-1:0]];
      sat_ff   <= sat_b;
   end

   always_ff @(posedge clock) begin
      lo_dly_ff[0] <= t_lo_ff;
      for (int k = 1; k < MulLatency; k++) begin
         lo_dly_ff[k] <= lo_dly_ff[k-1];
      end
      sat_dly_ff[0] <= sat_ff;
      for (int k = 1; k < 2 * MulLatency; k++) begin
         sat_dly_ff[k] <= sat_dly_ff[k-1];
      end
      g_dly_ff[0] <= g_ff;
      for (int k = 1; k < MulLatency; k++) begin
         g_dly_ff[k] <= g_dly_ff[k-1];
      end
   end

   afu_mul #(.Width(ExpWidth), .Frac(ExpFrac)) u_mul_hi_mid (
      .clock (clock),
      .a     (t_hi_ff),
      .b     (t_mid_ff),
      .p     (p_hm)
   );

   afu_mul #(.Width(ExpWidth), .Frac(ExpFrac)) u_mul_lo (
      .clock (clock),
      .a     (p_hm),
      .b     (lo_dly_ff[MulLatency-1]),
      .p     (g_raw)
   );

   always_ff @(posedge clock) begin
      g_ff <= sat_dly_ff[2*MulLatency-1] ? '0 : g_raw;
   end

   afu_mul #(.Width(ExpWidth), .Frac(ExpFrac)) u_mul_sq (
      .clock (clock),
      .a     (g_ff),
      .b     (g_ff),
      .p     (gg)
   );

   // numerator and denominator
   always_comb begin
      g_n           = NumWidth'(g_dly_ff[MulLatency-1]);
      gg_n          = NumWidth'(gg);
      one_plus_g    = QOne + g_n;
      one_plus_g_sq = QOne + (g_n << 1) + gg_n;
      neg_n         = side_ff[StMul3].x[DataWidth-1];
      case (func_type'(side_ff[StMul3].func))
         FuncSigmoid: begin
            num_in = neg_n ? g_n : QOne;
            den_in = one_plus_g;
         end
         FuncSigmoidDeriv: begin
            num_in = g_n;
            den_in = one_plus_g_sq;
         end
         FuncTanh: begin
            num_in = QOne - g_n;
            den_in = one_plus_g;
         end
         FuncTanhDeriv: begin
            num_in = g_n << 2;
            den_in = one_plus_g_sq;
         end
         default: begin
            num_in = '0;
            den_in = QOne;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
   end

   afu_div #(.Width(NumWidth), .QuotBits(QuotBits)) u_div (
      .clock (clock),
      .num   (num_ff),
      .den   (den_ff),
      .quot  (quot)
   );

   // round half up on magnitude, then sign and selection
   always_comb begin
      quot_up = {1'b0, quot} + (QuotBits + 1)'(1);
      mag     = DataWidth'(quot_up[QuotBits:1]);
      neg_o   = side_ff[StDiv].x[DataWidth-1];
      case (func_type'(side_ff[StDiv].func))
         FuncSigmoid:      rsp_y_in = mag;
         FuncSigmoidDeriv: rsp_y_in = mag;
         FuncRelu:         rsp_y_in = neg_o ? '0 : side_ff[StDiv].x;
         FuncReluDeriv:    rsp_y_in = neg_o ? '0 : YOne;
         FuncTanh:         rsp_y_in = neg_o ? (~mag + DataWidth'(1)) : mag;
         FuncTanhDeriv:    rsp_y_in = mag;
         default:          rsp_y_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_y_ff <= rsp_y_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_y      = rsp_y_ff;

endmodule

@@ sim/tb_top.sv @@
// Testbench for activation_function_unit: drives (func, x) words through the
// command port, predicts each y with an integer Q60 model, checks every strobe.
// Depends on afu_pkg and the activation_function_unit RTL.
module tb_top;
   import afu_pkg::*;

   localparam int CycleLimit = 200000;
   localparam int DrainCycles = 30;
   localparam int QBits = 60;
   localparam int ArgShift = QBits - 7 - FracBits;
   localparam logic [63:0] QOne = 64'd1 << QBits;
   localparam logic [FuncWidth-1:0] FuncSpareLo = 3'd6;
   localparam logic [FuncWidth-1:0] FuncSpareHi = 3'd7;

   typedef struct {
      logic        [FuncWidth-1:0] func;
      logic signed [DataWidth-1:0] x;
      logic signed [DataWidth-1:0] y;
   } act_word_type;

   logic                        clock;
   logic                        reset;
   logic                        start;
   logic                        busy;
   logic        [FuncWidth-1:0] req_func;
   logic signed [DataWidth-1:0] req_x;
   logic                        rsp_strobe;
   logic signed [DataWidth-1:0] rsp_y;

   act_word_type y_pending[$];
   int        error_count;
   int        cycle_count;

   activation_function_unit dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_func   (req_func),
      .req_x      (req_x),
      .rsp_strobe (rsp_strobe),
      .rsp_y      (rsp_y)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // (a * b) >> 60, truncated
   function automatic logic [63:0] q60_mul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[QBits+63:QBits];
   endfunction

   // exp(-u / 2^FracBits) in Q60: series on u / 2^FracBits / 128, then squared seven times
   function automatic logic [63:0] q60_exp_neg(input logic [63:0] u);
      logic [63:0] v;
      logic [63:0] sum;
      logic [63:0] term;
      v    = u << ArgShift;
      sum  = QOne;
      term = QOne;
      for (int k = 1; k <= 24; k++) begin
         term = q60_mul(term, v) / 64'(k);
         if (k % 2 == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      for (int k = 0; k < 7; k++) begin
         sum = q60_mul(sum, sum);
      end
      return sum;
   endfunction

   // num / den scaled by 2^FracBits, rounded half up
   function automatic longint q60_div_round(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] q;
      logic [63:0] rem;
      q   = num / den;
      rem = num % den;
      for (int i = 0; i <= FracBits; i++) begin
         rem = rem << 1;
         q   = q << 1;
         if (rem >= den) begin
            rem  = rem - den;
            q[0] = 1'b1;
         end
      end
      return longint'((q + 64'd1) >> 1);
   endfunction

   function automatic logic signed [DataWidth-1:0] predict_y(
      input logic [FuncWidth-1:0] f, input logic signed [DataWidth-1:0] x);
      logic        neg;
      logic [63:0] ax;
      logic [63:0] e;
      logic [63:0] e2;
      logic [63:0] d;
      longint      y;
      longint      ymax;
      neg  = x < 0;
      ax   = neg ? 64'(-longint'(x)) : 64'(longint'(x));
      e    = '0;
      e2   = '0;
      y    = 0;
      ymax = (longint'(1) <<< (DataWidth - 1)) - 1;
      if (ax < (64'd32 << FracBits)) begin
         e  = q60_exp_neg(ax);
         e2 = q60_exp_neg(ax << 1);
      end
      case (f)
         FuncSigmoid: begin
            d = QOne + e;
            y = q60_div_round(neg ? e : QOne, d);
         end
         FuncSigmoidDeriv: begin
            d = QOne + e;
            y = q60_div_round(e, q60_mul(d, d));
         end
         FuncRelu:      y = neg ? 0 : longint'(x);
         FuncReluDeriv: y = neg ? 0 : (longint'(1) <<< FracBits);
         FuncTanh: begin
            y = q60_div_round(QOne - e2, QOne + e2);
            if (neg) begin
               y = -y;
            end
         end
         FuncTanhDeriv: begin
            d = QOne + e2;
            y = q60_div_round(e2 << 2, q60_mul(d, d));
         end
         default: y = 0;
      endcase
      if (y > ymax) begin
         y = ymax;
      end
      if (y < -ymax - 1) begin
         y = -ymax - 1;
      end
      return y[DataWidth-1:0];
   endfunction

   // transcendental functions may be off by one LSB, the rest must be exact
   function automatic bit is_approx(input logic [FuncWidth-1:0] f);
      case (f)
         FuncSigmoid, FuncSigmoidDeriv, FuncTanh, FuncTanhDeriv: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   always @(posedge clock) begin : y_monitor
      act_word_type exp_word;
      int        diff;
      if (!reset) begin
         if (start && !busy) begin
            exp_word.func = req_func;
            exp_word.x    = req_x;
            exp_word.y    = predict_y(req_func, req_x);
            y_pending.push_back(exp_word);
         end
         if ($isunknown(rsp_strobe)) begin
            $error("rsp_strobe unknown");
            error_count++;
         end else if (rsp_strobe) begin
            if (y_pending.size() == 0) begin
               $error("y mismatch: expected none, actual %0d", rsp_y);
               error_count++;
            end else begin
               exp_word = y_pending.pop_front();
               diff = int'(rsp_y) - int'(exp_word.y);
               if ($isunknown(rsp_y) || (is_approx(exp_word.func) ? (diff > 1 || diff < -1)
                                                                 : (diff != 0))) begin
                  $error("y mismatch: expected %0d, actual %0d (func %0d, x %0d)",
                         exp_word.y, rsp_y, exp_word.func, exp_word.x);
                  error_count++;
               end
            end
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // called at a falling edge; returns at the falling edge after the word is taken
   task automatic send_word(input logic [FuncWidth-1:0] f, input logic [DataWidth-1:0] x);
      start    <= 1'b1;
      req_func <= f;
      req_x    <= x;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   task automatic idle_cycles(input int n);
      start <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   task automatic wait_drain();
      start <= 1'b0;
      do begin
         @(negedge clock);
      end while (y_pending.size() != 0);
   endtask

   function automatic logic [DataWidth-1:0] random_x();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 4) begin
         return DataWidth'($urandom);
      end else if (sel < 8) begin
         return DataWidth'($urandom_range(0, 16384) - 8192);
      end else begin
         return DataWidth'($urandom_range(0, 128) - 64);
      end
   endfunction

   function automatic logic [FuncWidth-1:0] random_func();
      if ($urandom_range(0, 15) == 0) begin
         return FuncWidth'($urandom_range(FuncSpareLo, FuncSpareHi));
      end
      return FuncWidth'($urandom_range(FuncSigmoid, FuncTanhDeriv));
   endfunction

   task automatic test_special_values();
      for (int f = 0; f < 8; f++) begin
         send_word(FuncWidth'(f), '0);
      end
      for (int f = FuncSigmoid; f <= FuncTanhDeriv; f++) begin
         send_word(FuncWidth'(f), 16'sh8000);
         send_word(FuncWidth'(f), 16'sh7fff);
      end
      send_word(FuncRelu, -16'sd1);
      send_word(FuncReluDeriv, -16'sd1);
      send_word(FuncTanh, 16'sd1);
      send_word(FuncSigmoid, -16'sd1);
   endtask

   task automatic test_random_with_gaps(input int n);
      for (int i = 0; i < n; i++) begin
         if (i == n / 2) begin
            wait_drain();
         end
         if ($urandom_range(0, 3) == 0) begin
            idle_cycles($urandom_range(1, 12));
         end
         send_word(random_func(), random_x());
      end
   endtask

   task automatic test_back_to_back(input int n);
      for (int i = 0; i < n; i++) begin
         send_word(random_func(), random_x());
      end
   endtask

   task automatic finish_run();
      wait_drain();
      repeat (DrainCycles) @(negedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   endtask

   initial begin
      error_count = 0;
      reset       = 1'b1;
      start       = 1'b0;
      req_func    = '0;
      req_x       = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_special_values();
      test_random_with_gaps(1000);
      test_back_to_back(500);
      finish_run();
   end

endmodule
